/* hw/rtl/breakpoint_table_interpolator_assert.svh */
// Assertion macros for the breakpoint table interpolator.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef BREAKPOINT_TABLE_INTERPOLATOR_ASSERT_SVH
`define BREAKPOINT_TABLE_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BTI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("breakpoint table interpolator: same-cycle check failed");
`define BTI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("breakpoint table interpolator: next-cycle check failed");
`else
`define BTI_ASSERT_IMP(label, ante, cons)
`define BTI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/bti_pkg.sv */
// Shared types, codes and constants of the breakpoint table interpolator.
// No dependencies; imported by every module of the block.
package bti_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int TABLE_DEPTH_DEF  = 64;

    localparam int PROD_W = 64;
    localparam int CNT_W  = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);
    localparam logic [32:0] Q_MAX = 33'h1_FFFF_FFFF;

    localparam logic [1:0] DIR_OFF = 2'b00;
    localparam logic [1:0] DIR_FWD = 2'b01;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_LENGTH = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_RSVD   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_INTERP  = 2'd0,
        ST_EXACT   = 2'd1,
        ST_OUTSIDE = 2'd2,
        ST_ACK     = 2'd3
    } t_status;

    typedef struct packed {
        t_func              func;
        logic [1:0]         channel;
        logic [5:0]         entry_index;
        logic signed [31:0] time_point;
        logic signed [31:0] entry_value;
        logic [6:0]         table_count;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [5:0]         segment;
        t_status            status;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] bp_time;
        logic signed [31:0] bp_value;
    } t_bp_entry;

    typedef struct packed {
        logic        start;
        logic        neg;
        logic [31:0] mv;
        logic [31:0] mx;
        logic [31:0] mt;
        logic [31:0] v0;
    } t_lerp_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] value;
    } t_lerp_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RDL,
        S_SRCH,
        S_RDT1,
        S_RDT0,
        S_DIV,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_FIN
    } t_lerp_state;

    // Magnitude of a 33-bit two's complement difference of two 32-bit values.
    function automatic logic [31:0] mag33(input logic [32:0] x);
        logic [32:0] n;
        n = x[32] ? (~x + 33'd1) : x;
        return n[31:0];
    endfunction

endpackage

/* hw/rtl/breakpoint_table_interpolator.sv */
// Breakpoint table interpolator, top level: sequencer, table lengths and segment cache.
// Items answered without a search pass from idle through at most S_RD0 and S_RDL to S_OUT.
// A query that finds its segment makes its search reads from the cached segment, reads seg+1 and seg,
// and then ends when exact, or waits for the bit-serial divider when it interpolates.
// One item is in work at a time; the next transfer is taken the cycle after the result loads.
// Synchronous active-low reset clears lengths, caches and control; direction resets to forward.
`include "breakpoint_table_interpolator_assert.svh"
module breakpoint_table_interpolator #(
    parameter int NUM_CHANNELS = bti_pkg::NUM_CHANNELS_DEF,
    parameter int TABLE_DEPTH  = bti_pkg::TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bti_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bti_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_data
);
    import bti_pkg::*;

    localparam int MEM_DEPTH = NUM_CHANNELS * TABLE_DEPTH;
    localparam int AW = $clog2(MEM_DEPTH);
    localparam int EW = $clog2(TABLE_DEPTH);
    localparam int LW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Control state.
    t_state             r_state, n_state;
    logic [1:0]         r_dir;
    logic [LW-1:0]      r_len   [NUM_CHANNELS];
    logic [EW-1:0]      r_cache [NUM_CHANNELS];
    logic               r_ovalid;

    // Per-item working registers.
    logic [CW-1:0]      r_ch, n_ch;
    logic [AW-1:0]      r_base, n_base;
    logic signed [31:0] r_t, n_t, r_t0, n_t0, r_t1, n_t1, r_v1, n_v1;
    logic [EW-1:0]      r_i, n_i, r_seg, n_seg;
    logic               r_up, n_up, r_first, n_first;
    t_out_item          r_res, n_res, r_out;

    // Memory port signals.
    logic      w_mem_we;
    logic [AW-1:0] w_waddr, w_raddr;
    t_bp_entry w_wdata, w_rd;

    // Table length and cache updates.
    logic          w_len_we, w_cache_we;
    logic [LW-1:0] w_len_val;
    logic [EW-1:0] w_cache_val;

    // Decode of the incoming item.
    logic [CW-1:0] w_in_ch;
    logic [AW-1:0] w_in_base;
    logic          w_in_ch_ok, w_in_ei_ok;

    // Search helpers.
    logic [LW-1:0] w_len, w_lm1_full;
    logic [EW-1:0] w_lm1, w_cur, w_cache, w_cand, w_segf;
    logic          w_fwd, w_ge, w_a, w_eff_up, w_found, w_outside;
    logic [32:0]   w_dv, w_dx, w_dt;

    t_lerp_req w_req;
    t_lerp_rsp w_rsp;

    bti_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    bti_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Decoding of the input transfer. A channel or entry beyond the configured
    // storage is still acknowledged, but nothing is written.
    assign w_in_ch    = CW'(i_in_data.channel);
    assign w_in_base  = AW'(w_in_ch) * AW'(TABLE_DEPTH);
    assign w_in_ch_ok = 32'(i_in_data.channel) < NUM_CHANNELS;
    assign w_in_ei_ok = 32'(i_in_data.entry_index) < TABLE_DEPTH;
    assign w_waddr    = w_in_base + AW'(i_in_data.entry_index);
    assign w_wdata    = '{bp_time: i_in_data.time_point, bp_value: i_in_data.entry_value};
    assign w_len_val  = (32'(i_in_data.table_count) > TABLE_DEPTH) ? LW'(TABLE_DEPTH)
                                                                   : LW'(i_in_data.table_count);

    // Length and cached segment of the channel in work. A stale cache entry at or
    // beyond the current length starts the search at the last breakpoint.
    assign w_len      = r_len[r_ch];
    assign w_cache    = r_cache[r_ch];
    assign w_lm1_full = w_len - LW'(1);
    assign w_lm1      = w_lm1_full[EW-1:0];
    assign w_cur      = (w_cache > w_lm1) ? w_lm1 : w_cache;
    assign w_fwd      = (r_dir == DIR_FWD);

    // The search keeps one predicate: the breakpoint lies before t in table order.
    // Starting at the cached index it walks up while breakpoints are before t and
    // down while they are not, and stops where the predicate flips.
    assign w_ge      = w_rd.bp_time >= r_t;
    assign w_a       = w_fwd ? !w_ge : w_ge;
    assign w_eff_up  = r_first ? w_a : r_up;
    assign w_outside = w_fwd ? ((r_t < r_t0) || (r_t > w_rd.bp_time))
                             : ((r_t > r_t0) || (r_t < w_rd.bp_time));

    // Differences for the interpolation, read as seg+1 (registered) and seg (memory).
    assign w_dv = {r_v1[31], r_v1} - {w_rd.bp_value[31], w_rd.bp_value};
    assign w_dx = {r_t[31], r_t} - {w_rd.bp_time[31], w_rd.bp_time};
    assign w_dt = {r_t1[31], r_t1} - {w_rd.bp_time[31], w_rd.bp_time};

    assign w_req.neg = w_dv[32] ^ w_dx[32] ^ w_dt[32];
    assign w_req.mv  = mag33(w_dv);
    assign w_req.mx  = mag33(w_dx);
    assign w_req.mt  = mag33(w_dt);
    assign w_req.v0  = w_rd.bp_value;

    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_base      = r_base;
        n_t         = r_t;
        n_t0        = r_t0;
        n_t1        = r_t1;
        n_v1        = r_v1;
        n_i         = r_i;
        n_up        = r_up;
        n_first     = r_first;
        n_seg       = r_seg;
        n_res       = r_res;
        w_raddr     = r_base;
        w_mem_we    = 1'b0;
        w_len_we    = 1'b0;
        w_cache_we  = 1'b0;
        w_cache_val = '0;
        w_found     = 1'b0;
        w_cand      = '0;
        w_segf      = '0;
        w_req.start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_ch    = w_in_ch;
                    n_base  = w_in_base;
                    n_t     = i_in_data.time_point;
                    w_raddr = w_in_base;
                    n_res   = '{result_value: '0, segment: '0, status: ST_OUTSIDE};
                    n_state = S_OUT;
                    unique case (i_in_data.func)
                        FUNC_WRITE: begin
                            w_mem_we     = w_in_ch_ok && w_in_ei_ok;
                            n_res.status = ST_ACK;
                        end
                        FUNC_LENGTH: begin
                            w_len_we     = w_in_ch_ok;
                            n_res.status = ST_ACK;
                        end
                        FUNC_QUERY: begin
                            if (w_in_ch_ok) begin
                                n_state = S_RD0;
                            end
                        end
                        FUNC_RSVD: begin
                        end
                    endcase
                end
            end
            S_RD0: begin
                // First breakpoint: the single-entry hit is checked before direction.
                n_t0 = w_rd.bp_time;
                if (w_len == LW'(1) && w_rd.bp_time == r_t) begin
                    n_res.result_value = w_rd.bp_value;
                    n_res.status       = ST_EXACT;
                    n_state            = S_OUT;
                end else if (w_len == '0 || r_dir == DIR_OFF) begin
                    n_state = S_OUT;
                end else begin
                    w_raddr = r_base + AW'(w_lm1);
                    n_state = S_RDL;
                end
            end
            S_RDL: begin
                if (w_outside || w_len < LW'(2)) begin
                    n_state = S_OUT;
                end else begin
                    n_i     = w_cur;
                    n_first = 1'b1;
                    w_raddr = r_base + AW'(w_cur);
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                n_first = 1'b0;
                n_up    = w_eff_up;
                if (!r_first && (w_a != r_up)) begin
                    w_found = 1'b1;
                    w_cand  = r_up ? (r_i - EW'(1)) : r_i;
                end else if (w_eff_up) begin
                    if (LW'(r_i) + LW'(1) < w_len) begin
                        n_i     = r_i + EW'(1);
                        w_raddr = r_base + AW'(r_i) + AW'(1);
                    end else begin
                        w_found = 1'b1;
                    end
                end else begin
                    if (r_i != '0) begin
                        n_i     = r_i - EW'(1);
                        w_raddr = r_base + AW'(r_i) - AW'(1);
                    end else begin
                        w_found = 1'b1;
                    end
                end
                if (w_found) begin
                    // A segment starting at the last breakpoint falls back to zero.
                    w_segf      = (LW'(w_cand) + LW'(1) >= w_len) ? '0 : w_cand;
                    n_seg       = w_segf;
                    w_cache_we  = 1'b1;
                    w_cache_val = w_segf;
                    w_raddr     = r_base + AW'(w_segf) + AW'(1);
                    n_state     = S_RDT1;
                end
            end
            S_RDT1: begin
                n_t1    = w_rd.bp_time;
                n_v1    = w_rd.bp_value;
                w_raddr = r_base + AW'(r_seg);
                n_state = S_RDT0;
            end
            S_RDT0: begin
                n_res.segment = 6'(r_seg);
                if (r_t1 == r_t) begin
                    n_res.result_value = r_v1;
                    n_res.status       = ST_EXACT;
                    n_state            = S_OUT;
                end else if (w_dt == '0) begin
                    // Duplicate breakpoint times: the segment start value stands.
                    n_res.result_value = w_rd.bp_value;
                    n_res.status       = ST_INTERP;
                    n_state            = S_OUT;
                end else begin
                    w_req.start  = 1'b1;
                    n_res.status = ST_INTERP;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    n_res.result_value = w_rsp.value;
                    n_state            = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers carry payload only and need no reset.
    always_ff @(posedge i_clk) begin
        r_ch    <= n_ch;
        r_base  <= n_base;
        r_t     <= n_t;
        r_t0    <= n_t0;
        r_t1    <= n_t1;
        r_v1    <= n_v1;
        r_i     <= n_i;
        r_up    <= n_up;
        r_first <= n_first;
        r_seg   <= n_seg;
        r_res   <= n_res;
    end

    // Direction register, written by the configuration transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_FWD;
        end else if (i_cfg_valid) begin
            r_dir <= i_cfg_data;
        end
    end

    // Table lengths and segment caches. The length write uses the channel of the
    // incoming transfer; the cache write the channel of the query in work.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_len[k]   <= '0;
                r_cache[k] <= '0;
            end
        end else begin
            if (w_len_we) begin
                r_len[w_in_ch] <= w_len_val;
            end
            if (w_cache_we) begin
                r_cache[r_ch] <= w_cache_val;
            end
        end
    end

    // Output register: the finished result moves here once the slot is free, so
    // the sequencer returns to idle while the result waits for its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && (!r_ovalid || i_out_ready)) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || i_out_ready)) begin
            r_out <= r_res;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // The divider only works while the sequencer waits for it.
    `BTI_ASSERT_IMP(a_lerp_only_in_div, w_rsp.busy, r_state == S_DIV)
    // The search pointer never leaves the stored table.
    `BTI_ASSERT_IMP(a_search_in_table, r_state == S_SRCH, LW'(r_i) < w_len)
    // A finished result is in the output register in the cycle after it leaves the sequencer.
    `BTI_ASSERT_NEXT(a_result_loaded, (r_state == S_OUT) && (!r_ovalid || i_out_ready), r_ovalid && (r_state == S_IDLE))

endmodule

/* hw/rtl/bti_mem.sv */
// Breakpoint store: one write port, one read port, registered read data.
// Depends on bti_pkg for the entry type.
module bti_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  bti_pkg::t_bp_entry i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output bti_pkg::t_bp_entry o_rdata
);
    import bti_pkg::*;

    t_bp_entry r_mem [DEPTH];
    t_bp_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/bti_lerp.sv */
// Interpolation unit: one 32x32 multiply, then a bit-serial 64/32 division,
// clamping and saturation. Depends on bti_pkg.
module bti_lerp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bti_pkg::t_lerp_req i_req,
    output bti_pkg::t_lerp_rsp o_rsp
);
    import bti_pkg::*;

    t_lerp_state      r_lstate, n_lstate;
    logic             r_neg, n_neg;
    logic [31:0]      r_mv, n_mv, r_mx, n_mx, r_mt, n_mt, r_v0, n_v0;
    logic [63:0]      r_p, n_p;
    logic [31:0]      r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [32:0] w_rem2;
    logic        w_ge;
    logic [32:0] w_qc;
    logic [34:0] w_sum;
    logic [31:0] w_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lstate <= L_IDLE;
        end else begin
            r_lstate <= n_lstate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_mv  <= n_mv;
        r_mx  <= n_mx;
        r_mt  <= n_mt;
        r_v0  <= n_v0;
        r_p   <= n_p;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_lstate = r_lstate;
        n_neg    = r_neg;
        n_mv     = r_mv;
        n_mx     = r_mx;
        n_mt     = r_mt;
        n_v0     = r_v0;
        n_p      = r_p;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        w_rem2   = {r_rem, r_p[63]};
        w_ge     = w_rem2 >= {1'b0, r_mt};
        unique case (r_lstate)
            L_IDLE: begin
                if (i_req.start) begin
                    n_neg    = i_req.neg;
                    n_mv     = i_req.mv;
                    n_mx     = i_req.mx;
                    n_mt     = i_req.mt;
                    n_v0     = i_req.v0;
                    n_lstate = L_MUL;
                end
            end
            L_MUL: begin
                n_p      = 64'(r_mv) * 64'(r_mx);
                n_rem    = '0;
                n_cnt    = '0;
                n_lstate = L_DIV;
            end
            L_DIV: begin
                n_rem = w_ge ? 32'(w_rem2 - {1'b0, r_mt}) : w_rem2[31:0];
                n_p   = {r_p[62:0], w_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_lstate = L_FIN;
                end
            end
            L_FIN: begin
                n_lstate = L_IDLE;
            end
        endcase
    end

    // Quotient clamped to 33 bits, signed, added to v0 and saturated.
    always_comb begin
        w_qc  = (r_p > 64'(Q_MAX)) ? Q_MAX : r_p[32:0];
        w_sum = {{3{r_v0[31]}}, r_v0} + (r_neg ? (~{2'b00, w_qc} + 35'd1) : {2'b00, w_qc});
        if (w_sum[34:31] == 4'b0000 || w_sum[34:31] == 4'b1111) begin
            w_val = w_sum[31:0];
        end else if (w_sum[34]) begin
            w_val = 32'h8000_0000;
        end else begin
            w_val = 32'h7FFF_FFFF;
        end
    end

    assign o_rsp.busy  = (r_lstate != L_IDLE);
    assign o_rsp.done  = (r_lstate == L_FIN);
    assign o_rsp.value = w_val;

endmodule
